### rtl/mpba_pkg.sv
// shared types and constants of the multi pool block allocator
`default_nettype none

package mpba_pkg;

    localparam int SIZE_REGS          = 4;
    localparam int LARGEST_BLOCK      = 256;
    localparam int CFG_IDX_W          = 3;
    localparam int RST_SLOTS_PER_POOL = 256;
    localparam int RST_POOLS_IN_USE   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POOLS_IN_USE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_POOL = 3'd5;

    localparam logic [8:0] RST_POOL_BYTES_0 = 9'd16;
    localparam logic [8:0] RST_POOL_BYTES_1 = 9'd32;
    localparam logic [8:0] RST_POOL_BYTES_2 = 9'd64;
    localparam logic [8:0] RST_POOL_BYTES_3 = 9'd128;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FIT     = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED  = 2'd2;
    localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

    typedef logic [8:0] t_pool_bytes;
    typedef t_pool_bytes [SIZE_REGS-1:0] t_pool_sizes;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_sts;

endpackage

`default_nettype wire

### rtl/mpba_ram.sv
// generic single write port ram with registered read
`default_nettype none

module mpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/mpba_fit_scan.sv
// best fit pool search, one size compare per cycle
`default_nettype none

module mpba_fit_scan (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [15:0]          i_bytes,
    input  wire mpba_pkg::t_pool_sizes i_sizes,
    input  wire logic [2:0]           i_pool_cnt,
    output mpba_pkg::t_scan_sts       o_sts,
    output logic      [1:0]           o_best
);

    logic       r_busy;
    logic       r_done;
    logic       r_found;
    logic [1:0] r_idx;
    logic [1:0] r_best;
    logic [8:0] r_best_size;

    logic [8:0] w_size;
    logic       w_fit;
    logic       w_better;
    logic       w_last;
    logic       w_in_range;
    logic       w_take;

    assign w_size     = i_sizes[r_idx];
    assign w_fit      = ({7'b0, w_size} >= i_bytes);
    assign w_better   = !r_found || (w_size < r_best_size);
    assign w_last     = ({1'b0, r_idx} == (i_pool_cnt - 3'd1));
    assign w_in_range = (32'(i_bytes) <= mpba_pkg::LARGEST_BLOCK);
    assign w_take     = r_busy && !i_start && w_fit && w_better;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_idx   <= 2'd0;
                r_found <= 1'b0;
                if (w_in_range && (i_pool_cnt != 3'd0)) begin
                    r_busy <= 1'b1;
                end else begin
                    r_done <= 1'b1;
                end
            end else if (r_busy) begin
                if (w_take) begin
                    r_found <= 1'b1;
                end
                r_idx <= r_idx + 2'd1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best      <= r_idx;
            r_best_size <= w_size;
        end
    end

    assign o_sts.done  = r_done;
    assign o_sts.found = r_found;
    assign o_best      = r_best;

endmodule

`default_nettype wire

### rtl/multi_pool_block_allocator.sv
// multi pool fixed block allocator top level with request sequencer
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------------
//  request  | i_in_valid / o_in_ready   | req_type, request_bytes, pool_select, slot_select
//  result   | o_out_valid / i_out_ready | status, pool_index, slot_index, free_slots, alloc_total
//  config   | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
// free: a slot ram read when the handle is in range; allocate: a fit scan that checks one
// enabled pool per cycle, plus one ram read when a recycled slot is popped.
// clear: a sweep over all 2**(PW+SW) entries (1024 at defaults) of the slot ram.
// after reset the same sweep runs before the first request is taken.
// a result waits in the output register; a request is taken only after the previous
// result has moved into it. configuration transfers are taken every cycle.
`default_nettype none

module multi_pool_block_allocator #(
    parameter int POOL_COUNT = 4,
    parameter int SLOT_DEPTH = 256
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic [15:0]                    i_request_bytes,
    input  wire logic [1:0]                     i_pool_select,
    input  wire logic [7:0]                     i_slot_select,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [1:0]                     o_status,
    output logic      [1:0]                     o_pool_index,
    output logic      [7:0]                     o_slot_index,
    output logic      [8:0]                     o_free_slots,
    output logic      [31:0]                    o_alloc_total,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mpba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [8:0]                     i_cfg_data
);

    localparam int PW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int SW = $clog2(SLOT_DEPTH);
    localparam int CW = $clog2(SLOT_DEPTH + 1);
    localparam int AW = PW + SW;
    localparam int DW = SW + 2;
    localparam int EN_CAP = (POOL_COUNT < mpba_pkg::SIZE_REGS) ? POOL_COUNT
                                                                : mpba_pkg::SIZE_REGS;
    localparam int FREE_RST_I = (mpba_pkg::RST_SLOTS_PER_POOL > SLOT_DEPTH) ? SLOT_DEPTH
                                : mpba_pkg::RST_SLOTS_PER_POOL;
    localparam logic [SW:0]   EMPTY    = (SW + 1)'(SLOT_DEPTH);
    localparam logic [CW-1:0] FREE_MAX = CW'(SLOT_DEPTH);
    localparam logic [CW-1:0] FREE_RST = CW'(FREE_RST_I);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_ALLOC  = 4'd4;
    localparam logic [3:0] S_POP    = 4'd5;
    localparam logic [3:0] S_FREE   = 4'd6;
    localparam logic [3:0] S_SWEEP  = 4'd7;
    localparam logic [3:0] S_POST   = 4'd8;

    // configuration
    mpba_pkg::t_pool_sizes r_cfg_sizes;
    logic [2:0]            r_cfg_pools;
    logic [8:0]            r_cfg_slots;

    // per pool state
    logic [SW:0]   r_head      [POOL_COUNT];
    logic [SW:0]   n_head      [POOL_COUNT];
    logic [CW-1:0] r_untouched [POOL_COUNT];
    logic [CW-1:0] n_untouched [POOL_COUNT];
    logic [CW-1:0] r_free      [POOL_COUNT];
    logic [CW-1:0] n_free      [POOL_COUNT];
    logic [31:0]   r_served    [POOL_COUNT];
    logic [31:0]   n_served    [POOL_COUNT];

    logic [3:0]    r_state;
    logic [3:0]    n_state;
    logic [AW-1:0] r_sweep;
    logic [AW-1:0] n_sweep;
    logic [PW-1:0] r_pool;
    logic [PW-1:0] n_pool;
    logic          r_out_valid;

    // latched request
    logic [1:0]  r_req;
    logic [15:0] r_bytes;
    logic [1:0]  r_psel;
    logic [7:0]  r_ssel;

    // staged result
    logic [1:0]  r_res_status;
    logic [1:0]  n_res_status;
    logic [1:0]  r_res_pool;
    logic [1:0]  n_res_pool;
    logic [7:0]  r_res_slot;
    logic [7:0]  n_res_slot;
    logic [8:0]  r_res_free;
    logic [8:0]  n_res_free;
    logic [31:0] r_res_total;
    logic [31:0] n_res_total;

    logic [1:0]  r_out_status;
    logic [1:0]  r_out_pool;
    logic [7:0]  r_out_slot;
    logic [8:0]  r_out_free;
    logic [31:0] r_out_total;

    logic          w_in_xfer;
    logic          w_load_out;
    logic [CW-1:0] w_slot_cnt;
    logic [2:0]    w_en;
    logic          w_psel_ok;
    logic          w_psel_exists;
    logic          w_ssel_ok;
    logic [SW:0]   w_cur_head;
    logic [CW-1:0] w_cur_untouched;
    logic [CW-1:0] w_cur_free;
    logic [31:0]   w_cur_served;
    logic [CW-1:0] w_free_dec;
    logic [CW-1:0] w_free_inc;
    logic [31:0]   w_served_inc;
    logic [8:0]   w_psel_free;
    logic [31:0]  w_psel_total;

    logic          w_scan_start;
    mpba_pkg::t_scan_sts w_scan_sts;
    logic [1:0]    w_scan_best;

    logic          w_ram_wr_en;
    logic [AW-1:0] w_ram_wr_addr;
    logic [DW-1:0] w_ram_wr_data;
    logic          w_ram_rd_en;
    logic [AW-1:0] w_ram_rd_addr;
    logic [DW-1:0] w_ram_rd_data;
    logic          w_rd_in_use;
    logic [SW:0]   w_rd_link;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;

    assign w_rd_in_use = w_ram_rd_data[SW+1];
    assign w_rd_link   = w_ram_rd_data[SW:0];

    always_comb begin
        if (32'(r_cfg_slots) > SLOT_DEPTH) begin
            w_slot_cnt = CW'(SLOT_DEPTH);
        end else begin
            w_slot_cnt = CW'(r_cfg_slots);
        end
        if (32'(r_cfg_pools) > EN_CAP) begin
            w_en = 3'(EN_CAP);
        end else begin
            w_en = r_cfg_pools;
        end
    end

    assign w_psel_ok     = ({1'b0, r_psel} < w_en);
    assign w_psel_exists = (32'(r_psel) < POOL_COUNT);
    assign w_ssel_ok     = (32'(r_ssel) < SLOT_DEPTH);

    assign w_cur_head      = r_head[r_pool];
    assign w_cur_untouched = r_untouched[r_pool];
    assign w_cur_free      = r_free[r_pool];
    assign w_cur_served    = r_served[r_pool];
    assign w_free_dec      = (w_cur_free != '0) ? (w_cur_free - CW'(1)) : w_cur_free;
    assign w_free_inc      = (w_cur_free < FREE_MAX) ? (w_cur_free + CW'(1)) : w_cur_free;
    assign w_served_inc    = w_cur_served + 32'd1;

    always_comb begin
        if (w_psel_exists) begin
            w_psel_free  = 9'(r_free[PW'(r_psel)]);
            w_psel_total = r_served[PW'(r_psel)];
        end else begin
            w_psel_free  = 9'd0;
            w_psel_total = 32'd0;
        end
    end

    mpba_fit_scan u_fit_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_scan_start),
        .i_bytes    (r_bytes),
        .i_sizes    (r_cfg_sizes),
        .i_pool_cnt (w_en),
        .o_sts      (w_scan_sts),
        .o_best     (w_scan_best)
    );

    mpba_ram #(
        .WIDTH (DW),
        .DEPTH (2 ** AW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (w_ram_wr_addr),
        .i_wr_data (w_ram_wr_data),
        .i_rd_en   (w_ram_rd_en),
        .i_rd_addr (w_ram_rd_addr),
        .o_rd_data (w_ram_rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_pool       = r_pool;
        n_head       = r_head;
        n_untouched  = r_untouched;
        n_free       = r_free;
        n_served     = r_served;
        n_res_status = r_res_status;
        n_res_pool   = r_res_pool;
        n_res_slot   = r_res_slot;
        n_res_free   = r_res_free;
        n_res_total  = r_res_total;
        w_scan_start  = 1'b0;
        w_load_out    = 1'b0;
        w_ram_wr_en   = 1'b0;
        w_ram_wr_addr = '0;
        w_ram_wr_data = '0;
        w_ram_rd_en   = 1'b0;
        w_ram_rd_addr = '0;

        unique case (r_state)
            S_INIT: begin
                w_ram_wr_en   = 1'b1;
                w_ram_wr_addr = r_sweep;
                n_sweep       = r_sweep + AW'(1);
                if (&r_sweep) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_req)
                    mpba_pkg::REQ_CLEAR: begin
                        for (int p = 0; p < POOL_COUNT; p++) begin
                            n_head[p]      = EMPTY;
                            n_untouched[p] = '0;
                            n_free[p]      = w_slot_cnt;
                            n_served[p]    = 32'd0;
                        end
                        n_sweep = '0;
                        n_state = S_SWEEP;
                    end
                    mpba_pkg::REQ_ALLOC: begin
                        w_scan_start = 1'b1;
                        n_state      = S_SCAN;
                    end
                    mpba_pkg::REQ_FREE: begin
                        if (w_psel_ok && w_ssel_ok) begin
                            n_pool        = PW'(r_psel);
                            w_ram_rd_en   = 1'b1;
                            w_ram_rd_addr = {PW'(r_psel), SW'(r_ssel)};
                            n_state       = S_FREE;
                        end else begin
                            n_res_status = mpba_pkg::ST_BAD_HANDLE;
                            n_res_pool   = r_psel;
                            n_res_slot   = r_ssel;
                            n_res_free   = w_psel_free;
                            n_res_total  = w_psel_total;
                            n_state      = S_POST;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (w_scan_sts.done) begin
                    if (w_scan_sts.found) begin
                        n_pool  = PW'(w_scan_best);
                        n_state = S_ALLOC;
                    end else begin
                        n_res_status = mpba_pkg::ST_NO_FIT;
                        n_res_pool   = 2'd0;
                        n_res_slot   = 8'd0;
                        n_res_free   = 9'd0;
                        n_res_total  = 32'd0;
                        n_state      = S_POST;
                    end
                end
            end
            S_ALLOC: begin
                n_res_pool = 2'(r_pool);
                if (w_cur_head < EMPTY) begin
                    w_ram_rd_en   = 1'b1;
                    w_ram_rd_addr = {r_pool, w_cur_head[SW-1:0]};
                    n_state       = S_POP;
                end else if (w_cur_untouched < w_slot_cnt) begin
                    n_untouched[r_pool] = w_cur_untouched + CW'(1);
                    n_free[r_pool]      = w_free_dec;
                    n_served[r_pool]    = w_served_inc;
                    w_ram_wr_en   = 1'b1;
                    w_ram_wr_addr = {r_pool, SW'(w_cur_untouched)};
                    w_ram_wr_data = {1'b1, (SW + 1)'(0)};
                    n_res_status  = mpba_pkg::ST_OK;
                    n_res_slot    = 8'(w_cur_untouched);
                    n_res_free    = 9'(w_free_dec);
                    n_res_total   = w_served_inc;
                    n_state       = S_POST;
                end else begin
                    n_res_status = mpba_pkg::ST_EXHAUSTED;
                    n_res_slot   = 8'd0;
                    n_res_free   = 9'(w_cur_free);
                    n_res_total  = w_cur_served;
                    n_state      = S_POST;
                end
            end
            S_POP: begin
                n_head[r_pool]   = w_rd_link;
                n_free[r_pool]   = w_free_dec;
                n_served[r_pool] = w_served_inc;
                w_ram_wr_en   = 1'b1;
                w_ram_wr_addr = {r_pool, w_cur_head[SW-1:0]};
                w_ram_wr_data = {1'b1, w_rd_link};
                n_res_status  = mpba_pkg::ST_OK;
                n_res_slot    = 8'(w_cur_head);
                n_res_free    = 9'(w_free_dec);
                n_res_total   = w_served_inc;
                n_state       = S_POST;
            end
            S_FREE: begin
                n_res_pool = r_psel;
                n_res_slot = r_ssel;
                if (!w_rd_in_use) begin
                    n_res_status = mpba_pkg::ST_BAD_HANDLE;
                    n_res_free   = 9'(w_cur_free);
                    n_res_total  = w_cur_served;
                end else begin
                    n_head[r_pool] = (SW + 1)'(r_ssel);
                    n_free[r_pool] = w_free_inc;
                    w_ram_wr_en   = 1'b1;
                    w_ram_wr_addr = {r_pool, SW'(r_ssel)};
                    w_ram_wr_data = {1'b0, w_cur_head};
                    n_res_status  = mpba_pkg::ST_OK;
                    n_res_free    = 9'(w_free_inc);
                    n_res_total   = w_cur_served;
                end
                n_state = S_POST;
            end
            S_SWEEP: begin
                w_ram_wr_en   = 1'b1;
                w_ram_wr_addr = r_sweep;
                n_sweep       = r_sweep + AW'(1);
                if (&r_sweep) begin
                    n_res_status = mpba_pkg::ST_OK;
                    n_res_pool   = 2'd0;
                    n_res_slot   = 8'd0;
                    n_res_free   = 9'(r_free[0]);
                    n_res_total  = r_served[0];
                    n_state      = S_POST;
                end
            end
            S_POST: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
            r_cfg_sizes[0] <= mpba_pkg::RST_POOL_BYTES_0;
            r_cfg_sizes[1] <= mpba_pkg::RST_POOL_BYTES_1;
            r_cfg_sizes[2] <= mpba_pkg::RST_POOL_BYTES_2;
            r_cfg_sizes[3] <= mpba_pkg::RST_POOL_BYTES_3;
            r_cfg_pools    <= 3'(mpba_pkg::RST_POOLS_IN_USE);
            r_cfg_slots    <= 9'(mpba_pkg::RST_SLOTS_PER_POOL);
            for (int p = 0; p < POOL_COUNT; p++) begin
                r_head[p]      <= EMPTY;
                r_untouched[p] <= '0;
                r_free[p]      <= FREE_RST;
                r_served[p]    <= 32'd0;
            end
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_head      <= n_head;
            r_untouched <= n_untouched;
            r_free      <= n_free;
            r_served    <= n_served;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mpba_pkg::CFG_POOL_BYTES_0:   r_cfg_sizes[0] <= i_cfg_data;
                    mpba_pkg::CFG_POOL_BYTES_1:   r_cfg_sizes[1] <= i_cfg_data;
                    mpba_pkg::CFG_POOL_BYTES_2:   r_cfg_sizes[2] <= i_cfg_data;
                    mpba_pkg::CFG_POOL_BYTES_3:   r_cfg_sizes[3] <= i_cfg_data;
                    mpba_pkg::CFG_POOLS_IN_USE:   r_cfg_pools    <= i_cfg_data[2:0];
                    mpba_pkg::CFG_SLOTS_PER_POOL: r_cfg_slots    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pool       <= n_pool;
        r_res_status <= n_res_status;
        r_res_pool   <= n_res_pool;
        r_res_slot   <= n_res_slot;
        r_res_free   <= n_res_free;
        r_res_total  <= n_res_total;
        if (w_in_xfer) begin
            r_req   <= i_req_type;
            r_bytes <= i_request_bytes;
            r_psel  <= i_pool_select;
            r_ssel  <= i_slot_select;
        end
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_pool   <= r_res_pool;
            r_out_slot   <= r_res_slot;
            r_out_free   <= r_res_free;
            r_out_total  <= r_res_total;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_pool_index  = r_out_pool;
    assign o_slot_index  = r_out_slot;
    assign o_free_slots  = r_out_free;
    assign o_alloc_total = r_out_total;

    ap_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_in_ready)
        else $error("request taken while previous one still in progress");

    ap_no_ram_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_ram_wr_en)
        else $error("slot ram written while idle");

    ap_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC || r_state == S_POP || r_state == S_FREE)
            |-> (w_cur_free <= FREE_MAX))
        else $error("free slot count above slot depth");

    ap_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_sts.done |-> (r_state == S_SCAN))
        else $error("fit scan finished outside scan state");

    ap_no_fit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == mpba_pkg::ST_NO_FIT)
            |-> (o_pool_index == 2'd0 && o_free_slots == 9'd0 && o_alloc_total == 32'd0))
        else $error("no fit result carries pool data");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// testbench for the multi pool block allocator: directed and random requests checked against a mirror
module tb_top;
    import mpba_pkg::*;

    localparam int POOL_COUNT      = 4;
    localparam int SLOT_DEPTH      = 256;
    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 150;
    localparam int TIMEOUT_CYCLES  = 800000;
    localparam int MAX_REPORTS     = 40;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  pool;
        logic [7:0]  slot;
        logic [8:0]  free_cnt;
        logic [31:0] total;
    } alloc_reply_t;

    typedef struct packed {
        logic [1:0] pool;
        logic [7:0] slot;
    } handle_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_req_type;
    logic [15:0]          i_request_bytes;
    logic [1:0]           i_pool_select;
    logic [7:0]           i_slot_select;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [1:0]           o_status;
    logic [1:0]           o_pool_index;
    logic [7:0]           o_slot_index;
    logic [8:0]           o_free_slots;
    logic [31:0]          o_alloc_total;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [8:0]           i_cfg_data;

    multi_pool_block_allocator #(
        .POOL_COUNT(POOL_COUNT),
        .SLOT_DEPTH(SLOT_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_request_bytes(i_request_bytes),
        .i_pool_select  (i_pool_select),
        .i_slot_select  (i_slot_select),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_pool_index   (o_pool_index),
        .o_slot_index   (o_slot_index),
        .o_free_slots   (o_free_slots),
        .o_alloc_total  (o_alloc_total),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // mirror of the allocator state and registers
    t_pool_sizes  m_size;
    logic [2:0]   m_pools_on;
    logic [8:0]   m_slots_reg;
    logic [8:0]   m_head   [POOL_COUNT];
    logic [8:0]   m_link   [POOL_COUNT][SLOT_DEPTH];
    logic [8:0]   m_fresh  [POOL_COUNT];
    logic [8:0]   m_free   [POOL_COUNT];
    logic [31:0]  m_served [POOL_COUNT];
    bit           m_busy   [POOL_COUNT][SLOT_DEPTH];

    alloc_reply_t expected_replies[$];
    handle_t      held_handles[$];

    int replies_owed;
    int replies_checked;
    int error_count;
    int clears_seen;
    int ignored_seen;
    int reg_writes;
    int status_tally [4];
    bit src_idle_on;
    bit sink_idle_on;
    bit hold_off_req;

    function automatic int pools_enabled();
        return (m_pools_on > 3'(POOL_COUNT)) ? POOL_COUNT : int'(m_pools_on);
    endfunction

    function automatic logic [8:0] slots_effective();
        return (m_slots_reg > 9'(SLOT_DEPTH)) ? 9'(SLOT_DEPTH) : m_slots_reg;
    endfunction

    function automatic alloc_reply_t make_reply(logic [1:0] st, logic [1:0] pool,
                                                logic [7:0] slot, logic [8:0] fr,
                                                logic [31:0] tot);
        alloc_reply_t r;
        r.status   = st;
        r.pool     = pool;
        r.slot     = slot;
        r.free_cnt = fr;
        r.total    = tot;
        return r;
    endfunction

    function automatic void mirror_clear();
        int p;
        int s;
        for (p = 0; p < POOL_COUNT; p++) begin
            m_head[p]   = 9'(SLOT_DEPTH);
            m_fresh[p]  = '0;
            m_free[p]   = slots_effective();
            m_served[p] = '0;
            for (s = 0; s < SLOT_DEPTH; s++) begin
                m_busy[p][s] = 1'b0;
            end
        end
        held_handles.delete();
    endfunction

    function automatic void mirror_reset();
        m_size[0]   = RST_POOL_BYTES_0;
        m_size[1]   = RST_POOL_BYTES_1;
        m_size[2]   = RST_POOL_BYTES_2;
        m_size[3]   = RST_POOL_BYTES_3;
        m_pools_on  = 3'(RST_POOLS_IN_USE);
        m_slots_reg = 9'(RST_SLOTS_PER_POOL);
        mirror_clear();
    endfunction

    function automatic void mirror_config(logic [CFG_IDX_W-1:0] idx, logic [8:0] data);
        reg_writes++;
        case (idx)
            CFG_POOL_BYTES_0:   m_size[0]   = data;
            CFG_POOL_BYTES_1:   m_size[1]   = data;
            CFG_POOL_BYTES_2:   m_size[2]   = data;
            CFG_POOL_BYTES_3:   m_size[3]   = data;
            CFG_POOLS_IN_USE:   m_pools_on  = data[2:0];
            CFG_SLOTS_PER_POOL: m_slots_reg = data;
            default: ;
        endcase
    endfunction

    // works out the reply to one accepted request and updates the mirror
    function automatic void mirror_request(logic [1:0] rt, logic [15:0] nb,
                                           logic [1:0] ps, logic [7:0] ss);
        int           en;
        int           p;
        int           best;
        bit           found;
        bit           got;
        logic [8:0]   slot;
        alloc_reply_t reply;
        en    = pools_enabled();
        best  = 0;
        found = 1'b0;
        got   = 1'b1;
        slot  = '0;
        case (rt)
            REQ_CLEAR: begin
                mirror_clear();
                clears_seen++;
                reply = make_reply(ST_OK, '0, '0, m_free[0], m_served[0]);
            end
            REQ_ALLOC: begin
                if (nb <= LARGEST_BLOCK) begin
                    for (p = 0; p < en; p++) begin
                        if (m_size[p] >= nb && (!found || m_size[p] < m_size[best])) begin
                            best  = p;
                            found = 1'b1;
                        end
                    end
                end
                if (!found) begin
                    reply = make_reply(ST_NO_FIT, '0, '0, '0, '0);
                end else begin
                    if (m_head[best] < SLOT_DEPTH) begin
                        slot         = m_head[best];
                        m_head[best] = m_link[best][slot[7:0]];
                    end else if (m_fresh[best] < slots_effective()) begin
                        slot          = m_fresh[best];
                        m_fresh[best] = slot + 9'd1;
                    end else begin
                        got = 1'b0;
                    end
                    if (!got) begin
                        reply = make_reply(ST_EXHAUSTED, 2'(best), '0, m_free[best],
                                           m_served[best]);
                    end else begin
                        m_busy[best][slot[7:0]] = 1'b1;
                        if (m_free[best] != '0) m_free[best] = m_free[best] - 9'd1;
                        m_served[best] = m_served[best] + 32'd1;
                        held_handles.push_back('{pool: 2'(best), slot: slot[7:0]});
                        reply = make_reply(ST_OK, 2'(best), slot[7:0], m_free[best],
                                           m_served[best]);
                    end
                end
            end
            REQ_FREE: begin
                if (ps >= en || !m_busy[ps][ss]) begin
                    reply = make_reply(ST_BAD_HANDLE, ps, ss, m_free[ps], m_served[ps]);
                end else begin
                    m_busy[ps][ss] = 1'b0;
                    m_link[ps][ss] = m_head[ps];
                    m_head[ps]     = {1'b0, ss};
                    if (m_free[ps] < SLOT_DEPTH) m_free[ps] = m_free[ps] + 9'd1;
                    reply = make_reply(ST_OK, ps, ss, m_free[ps], m_served[ps]);
                end
            end
            default: begin
                ignored_seen++;
                return;
            end
        endcase
        status_tally[reply.status]++;
        expected_replies.push_back(reply);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // prediction on each accepted transfer, checking on each result transfer
    always @(posedge i_clk) begin : scoreboard
        alloc_reply_t want;
        if (!i_rst_n) begin
            mirror_reset();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none actual status %0d",
                                 $time, o_status);
                end else begin
                    want = expected_replies.pop_front();
                    replies_checked++;
                    check_field("status", want.status, o_status);
                    check_field("pool_index", want.pool, o_pool_index);
                    check_field("slot_index", want.slot, o_slot_index);
                    check_field("free_slots", want.free_cnt, o_free_slots);
                    check_field("alloc_total", want.total, o_alloc_total);
                end
            end
            if (i_cfg_valid && o_cfg_ready) mirror_config(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                mirror_request(i_req_type, i_request_bytes, i_pool_select, i_slot_select);
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("tb_top NOT OK");
        $finish;
    end

    // result side: random stall bursts and one long hold-off on request
    initial begin : result_sink
        int gap;
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                i_out_ready <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                gap = $urandom_range(1, 10);
                repeat (gap) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic [1:0] rt, input logic [15:0] nb,
                                input logic [1:0] ps, input logic [7:0] ss);
        int gap;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= rt;
        i_request_bytes <= nb;
        i_pool_select   <= ps;
        i_slot_select   <= ss;
        if (rt != REQ_UNUSED) replies_owed++;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (replies_checked < replies_owed) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [8:0] random_block_size();
        case ($urandom_range(0, 9))
            0: return 9'd1;
            1: return 9'(LARGEST_BLOCK);
            2: return 9'($urandom_range(LARGEST_BLOCK + 1, 511));
            3: return 9'($urandom_range(1, 8));
            default: return 9'($urandom_range(1, LARGEST_BLOCK));
        endcase
    endfunction

    function automatic logic [8:0] random_pool_count();
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'($urandom_range(5, 7));
            2: return 9'd1;
            3: return 9'd4;
            default: return 9'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [8:0] random_slot_count();
        case ($urandom_range(0, 19))
            0: return 9'd0;
            1, 2: return 9'(SLOT_DEPTH);
            3: return 9'($urandom_range(SLOT_DEPTH + 1, 511));
            4: return 9'd1;
            default: return 9'($urandom_range(2, 12));
        endcase
    endfunction

    task automatic test_default_requests();
        send_request(REQ_ALLOC, 16'd0, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd16, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd17, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd128, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd129, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd257, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'hFFFF, 2'd3, 8'hFF);
        send_request(REQ_FREE, 16'd0, 2'd0, 8'd1);
        send_request(REQ_FREE, 16'd0, 2'd0, 8'd1);
        send_request(REQ_ALLOC, 16'd1, 2'd0, 8'd0);
        send_request(REQ_FREE, 16'hFFFF, 2'd3, 8'hFF);
        send_request(REQ_FREE, 16'd0, 2'd3, 8'd0);
        send_request(REQ_UNUSED, 16'hFFFF, 2'd3, 8'hFF);
        send_request(REQ_CLEAR, 16'hFFFF, 2'd3, 8'hFF);
        send_request(REQ_ALLOC, 16'd64, 2'd0, 8'd0);
        drain_results();
    endtask

    // ties, sizes past the largest block, pool and slot caps, no pools, saturation
    task automatic test_config_corners();
        write_reg(CFG_POOL_BYTES_0, 9'd8);
        write_reg(CFG_POOL_BYTES_1, 9'd8);
        write_reg(CFG_POOL_BYTES_2, 9'd1);
        write_reg(CFG_POOL_BYTES_3, 9'd300);
        write_reg(CFG_POOLS_IN_USE, 9'd7);
        write_reg(CFG_SLOTS_PER_POOL, 9'd511);
        send_request(REQ_CLEAR, 16'd0, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd8, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd9, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd256, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd0, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd1, 2'd0, 8'd0);
        drain_results();
        write_reg(CFG_POOLS_IN_USE, 9'd0);
        send_request(REQ_ALLOC, 16'd1, 2'd0, 8'd0);
        send_request(REQ_FREE, 16'd0, 2'd0, 8'd0);
        drain_results();
        write_reg(CFG_POOLS_IN_USE, 9'd1);
        write_reg(CFG_SLOTS_PER_POOL, 9'd0);
        send_request(REQ_CLEAR, 16'd0, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd1, 2'd0, 8'd0);
        drain_results();
        write_reg(CFG_SLOTS_PER_POOL, 9'd2);
        send_request(REQ_ALLOC, 16'd1, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd1, 2'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd1, 2'd0, 8'd0);
        send_request(REQ_FREE, 16'd0, 2'd0, 8'd1);
        drain_results();
    endtask

    // result side holds off while requests keep coming, so the block backs up
    task automatic test_backpressure();
        handle_t h;
        int      k;
        write_reg(CFG_POOL_BYTES_0, RST_POOL_BYTES_0);
        write_reg(CFG_POOL_BYTES_1, RST_POOL_BYTES_1);
        write_reg(CFG_POOL_BYTES_2, RST_POOL_BYTES_2);
        write_reg(CFG_POOL_BYTES_3, RST_POOL_BYTES_3);
        write_reg(CFG_POOLS_IN_USE, 9'(RST_POOLS_IN_USE));
        write_reg(CFG_SLOTS_PER_POOL, 9'(RST_SLOTS_PER_POOL));
        send_request(REQ_CLEAR, 16'd0, 2'd0, 8'd0);
        drain_results();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_off_req = 1'b1;
        for (k = 0; k < 24; k++) begin
            if (k % 3 == 2 && held_handles.size() > 0) begin
                h = held_handles.pop_front();
                send_request(REQ_FREE, 16'($urandom()), h.pool, h.slot);
            end else begin
                send_request(REQ_ALLOC, 16'($urandom_range(0, 160)), 2'($urandom()),
                             8'($urandom()));
            end
        end
        drain_results();
    endtask

    task automatic test_random_traffic(input int n_items, input bit calm);
        int          done;
        int          k;
        int          r;
        handle_t     h;
        logic [15:0] nb;
        src_idle_on  = !calm && ($urandom_range(0, 3) != 0);
        sink_idle_on = !calm && ($urandom_range(0, 3) != 0);
        for (k = 0; k < SIZE_REGS; k++)
            write_reg(CFG_POOL_BYTES_0 + CFG_IDX_W'(k), random_block_size());
        write_reg(CFG_POOLS_IN_USE, random_pool_count());
        write_reg(CFG_SLOTS_PER_POOL, random_slot_count());
        if ($urandom_range(0, 3) != 0)
            send_request(REQ_CLEAR, 16'($urandom()), 2'($urandom()), 8'($urandom()));
        done = 0;
        while (done < n_items) begin
            r = $urandom_range(0, 99);
            if (r >= 45 && r < 80 && held_handles.size() > 0) begin
                k = $urandom_range(0, held_handles.size() - 1);
                h = held_handles[k];
                held_handles.delete(k);
                send_request(REQ_FREE, 16'($urandom()), h.pool, h.slot);
            end else if (r < 80) begin
                k = $urandom_range(0, SIZE_REGS - 1);
                if ($urandom_range(0, 1) != 0)
                    nb = 16'($urandom_range(0, LARGEST_BLOCK));
                else
                    nb = 16'(m_size[k]) + 16'($urandom_range(0, 1));
                send_request(REQ_ALLOC, nb, 2'($urandom()), 8'($urandom()));
            end else if (r < 88) begin
                send_request(REQ_FREE, 16'($urandom()), 2'($urandom()),
                             ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 15))
                                                         : 8'($urandom()));
            end else if (r < 94) begin
                send_request(REQ_ALLOC, 16'($urandom()), 2'($urandom()), 8'($urandom()));
            end else if (r < 97) begin
                send_request(REQ_UNUSED, 16'($urandom()), 2'($urandom()), 8'($urandom()));
                done--;
            end else begin
                send_request(REQ_CLEAR, 16'($urandom()), 2'($urandom()), 8'($urandom()));
            end
            done++;
        end
        drain_results();
    endtask

    initial begin : main_sequence
        int ph;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_req_type      <= REQ_CLEAR;
        i_request_bytes <= '0;
        i_pool_select   <= '0;
        i_slot_select   <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_POOL_BYTES_0;
        i_cfg_data      <= '0;
        src_idle_on     = 1'b1;
        sink_idle_on    = 1'b1;
        hold_off_req    = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the block clears its slot memory before taking the first request
        do @(posedge i_clk); while (o_in_ready !== 1'b1);

        test_default_requests();
        test_config_corners();
        test_backpressure();
        for (ph = 0; ph < RANDOM_PHASES; ph++)
            test_random_traffic(PHASE_ITEMS, ph == RANDOM_PHASES - 1);
        drain_results();

        $display("run covered %0d results after %0d register writes: %0d ok, %0d no fit,",
                 replies_checked, reg_writes, status_tally[ST_OK], status_tally[ST_NO_FIT]);
        $display("  %0d exhausted, %0d bad handle, %0d clears, %0d ignored requests",
                 status_tally[ST_EXHAUSTED], status_tally[ST_BAD_HANDLE], clears_seen,
                 ignored_seen);
        if (expected_replies.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, expected_replies.size());
        if (error_count == 0 && expected_replies.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

### files.f
rtl/mpba_pkg.sv
rtl/mpba_ram.sv
rtl/mpba_fit_scan.sv
rtl/multi_pool_block_allocator.sv
tb/sv/tb_top.sv
